[hdl/assert_macros.svh]
// Assertion macros shared by the buffer pool RTL.
// Needs only a clock and an active-high reset from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCBP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define SCBP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[hdl/scbp_pkg.sv]
// Package for the size class buffer pool: codes, register indexes, defaults
// and the sequencer state type. No dependencies.
package scbp_pkg;

   localparam int MAX_CLASSES_DEF     = 4;
   localparam int MAX_QUEUES_DEF      = 8;
   localparam int SLOTS_PER_QUEUE_DEF = 256;
   localparam int NUM_SIZE_REGS       = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_CLASS_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS0_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS1_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS2_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLASS3_SIZE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NUM_QUEUES  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BUFS_PER_CL = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FC_THRESH   = 3'd7;

   localparam logic [2:0]  CLASS_COUNT_RST = 3'd1;
   localparam logic [23:0] CLASS0_SIZE_RST = 24'd1024;
   localparam logic [23:0] CLASS1_SIZE_RST = 24'd4096;
   localparam logic [23:0] CLASS2_SIZE_RST = 24'd16384;
   localparam logic [23:0] CLASS3_SIZE_RST = 24'd65536;
   localparam logic [3:0]  NUM_QUEUES_RST  = 4'd4;
   localparam logic [11:0] BUFS_PER_CL_RST = 12'd1024;
   localparam logic [7:0]  FC_THRESH_RST   = 8'd10;

   localparam logic [1:0] MODE_ALLOC    = 2'd0;
   localparam logic [1:0] MODE_ALLOC_FC = 2'd1;
   localparam logic [1:0] MODE_FREE     = 2'd2;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_CLASS  = 2'd1,
      ST_NO_BUFFER = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_CLASS,
      S_SWEEP,
      S_POP,
      S_OUT
   } state_type;

endpackage

[hdl/scbp_if.sv]
// Valid/ready channel interfaces for the buffer pool request and response.
// No dependencies.
interface scbp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [23:0] length;
   logic [1:0]  free_class;
   logic [2:0]  free_queue;
   logic [7:0]  free_slot;

   modport source (output valid, mode, length, free_class, free_queue, free_slot,
                   input ready);
   modport sink   (input valid, mode, length, free_class, free_queue, free_slot,
                   output ready);
endinterface

interface scbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [1:0] buf_class;
   logic [2:0] buf_queue;
   logic [7:0] buf_slot;

   modport source (output valid, status, buf_class, buf_queue, buf_slot,
                   input ready);
   modport sink   (input valid, status, buf_class, buf_queue, buf_slot,
                   output ready);
endinterface

[hdl/scbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/scbp_div.sv]
// Restoring divider, one quotient bit per cycle, for the queue share split.
// No dependencies.
module scbp_div #(
   parameter int N_W = 12,
   parameter int D_W = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [N_W-1:0] quotient,
   output logic [D_W-1:0] remainder
);
   localparam int CW = $clog2(N_W + 1);

   logic           busy_ff, busy_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [N_W-1:0] quo_ff, quo_in;
   logic [D_W-1:0] rem_ff, rem_in;
   logic [D_W:0]   trial;
   logic [D_W:0]   dvs;
   logic           ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[N_W-1]};
      dvs     = {1'b0, divisor};
      ge      = (trial >= dvs);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(N_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in = ge ? D_W'(trial - dvs) : D_W'(trial);
         quo_in = {quo_ff[N_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

[hdl/size_class_buffer_pool.sv]
// Top level of the size class buffer pool: sequencer, state and registers.
// Depends on scbp_pkg, scbp_if, scbp_ram, scbp_div and assert_macros.svh.
//
// Use: requests arrive on req_ch (valid/ready); mode 0 allocates, mode 1
// allocates under flow control, mode 2 frees a buffer handle. Each request
// yields one response on rsp_ch with a status and, on a good allocation, the
// class, queue and slot of the buffer. Registers are written through the
// csr port (csr_we, csr_index, csr_wdata); the user must write them only
// while the block is idle, the block itself does not enforce it.
// Sequence: a free or a bad mode goes through S_DISPATCH and S_OUT to the
// response register. An allocation goes through S_DISPATCH, S_CLASS, with
// the classes compared (1 to 4, one per cycle), S_SWEEP, with the queues
// tried (1 to the number of queues in use, one per cycle), and S_OUT; a
// successful pop adds S_POP for the ring memory read.
// One request is in work at a time; req_ch.ready is low meanwhile.
// Reset, and any write to the queue number or buffers_per_class, start a pass
// that rewrites the slot ring memory, one entry a cycle, and splits the
// buffers over the queues; no request is taken during the pass.
// A stalled receiver holds the response register; the next request is
// still taken and waits at its end until the response is free.
`include "assert_macros.svh"

module size_class_buffer_pool #(
   parameter int MAX_CLASSES     = scbp_pkg::MAX_CLASSES_DEF,
   parameter int MAX_QUEUES      = scbp_pkg::MAX_QUEUES_DEF,
   parameter int SLOTS_PER_QUEUE = scbp_pkg::SLOTS_PER_QUEUE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   scbp_req_if.sink                         req_ch,
   scbp_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [scbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import scbp_pkg::*;

   localparam int NQ    = MAX_CLASSES * MAX_QUEUES;
   localparam int IDW   = (NQ > 1) ? $clog2(NQ) : 1;
   localparam int QW    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
   localparam int CW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int QCW   = $clog2(MAX_QUEUES + 1);
   localparam int SW    = $clog2(SLOTS_PER_QUEUE);
   localparam int CNT_W = $clog2(SLOTS_PER_QUEUE + 1);
   localparam int DEPTH = NQ * SLOTS_PER_QUEUE;
   localparam int AW    = $clog2(DEPTH);
   localparam int MAX_CLS_EFF = (MAX_CLASSES < NUM_SIZE_REGS) ? MAX_CLASSES : NUM_SIZE_REGS;
   localparam int PW    = 9 + CNT_W;

   // configuration registers
   logic [2:0]  class_count_ff;
   logic [23:0] class_size_ff [NUM_SIZE_REGS];
   logic [3:0]  num_queues_ff;
   logic [11:0] bufs_ff;
   logic [7:0]  fc_thr_ff;

   // sequencer state
   state_type        state_ff, state_in;
   logic             clr_start_ff, clr_start_in;
   logic             ring_done_ff, ring_done_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic [SW-1:0]    clr_pos_ff, clr_pos_in;

   logic [1:0]       mode_ff, mode_in;
   logic [23:0]      length_ff, length_in;
   logic [1:0]       fcls_ff, fcls_in;
   logic [2:0]       fq_ff, fq_in;
   logic [7:0]       fslot_ff, fslot_in;

   logic [1:0]       cls_ff, cls_in;
   logic [QCW-1:0]   try_ff, try_in;
   logic [QW-1:0]    qhit_ff, qhit_in;

   status_type       res_status_ff, res_status_in;
   logic [1:0]       res_class_ff, res_class_in;
   logic [2:0]       res_queue_ff, res_queue_in;
   logic [7:0]       res_slot_ff, res_slot_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [1:0]       rsp_class_ff, rsp_class_in;
   logic [2:0]       rsp_queue_ff, rsp_queue_in;
   logic [7:0]       rsp_slot_ff, rsp_slot_in;

   // per-queue state
   logic [SW-1:0]    head_ff  [NQ];
   logic [SW-1:0]    head_in  [NQ];
   logic [CNT_W-1:0] count_ff [NQ];
   logic [CNT_W-1:0] count_in [NQ];
   logic [QW-1:0]    rr_ff    [MAX_CLASSES];
   logic [QW-1:0]    rr_in    [MAX_CLASSES];

   // shared units
   logic             div_start, div_busy;
   logic [11:0]      div_quo;
   logic [QCW-1:0]   div_rem;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [SW-1:0]    ram_wdata, ram_rdata;

   logic [QCW-1:0]   qc_eff;
   logic [2:0]       cc_eff;
   logic             cfg_reinit;

   logic [QW-1:0]    sweep_q, sweep_q_nxt;
   logic [IDW-1:0]   sweep_id, free_id;
   logic [CNT_W-1:0] sweep_cnt;
   logic [8:0]       thr1;
   logic [PW-1:0]    fc_prod;
   logic             sweep_hit;
   logic             free_bad;
   logic [7:0]       qext;
   logic [15:0]      sext;
   int               tail;

   function automatic logic [CNT_W-1:0] share_of(input int q);
      int s;
      s = 0;
      if (q < int'(qc_eff)) begin
         s = int'(div_quo) + ((q < int'(div_rem)) ? 1 : 0);
         if (s > SLOTS_PER_QUEUE) begin
            s = SLOTS_PER_QUEUE;
         end
      end
      return CNT_W'(s);
   endfunction

   always_comb begin
      if (num_queues_ff == 4'd0) begin
         qc_eff = QCW'(1);
      end else if (int'(num_queues_ff) > MAX_QUEUES) begin
         qc_eff = QCW'(MAX_QUEUES);
      end else begin
         qc_eff = QCW'(num_queues_ff);
      end
      if (class_count_ff == 3'd0) begin
         cc_eff = 3'd1;
      end else if (int'(class_count_ff) > MAX_CLS_EFF) begin
         cc_eff = 3'(MAX_CLS_EFF);
      end else begin
         cc_eff = class_count_ff;
      end
   end

   assign cfg_reinit = csr_we && (csr_index == REG_NUM_QUEUES || csr_index == REG_BUFS_PER_CL);

   always_ff @(posedge clock) begin
      if (reset) begin
         class_count_ff   <= CLASS_COUNT_RST;
         class_size_ff[0] <= CLASS0_SIZE_RST;
         class_size_ff[1] <= CLASS1_SIZE_RST;
         class_size_ff[2] <= CLASS2_SIZE_RST;
         class_size_ff[3] <= CLASS3_SIZE_RST;
         num_queues_ff    <= NUM_QUEUES_RST;
         bufs_ff          <= BUFS_PER_CL_RST;
         fc_thr_ff        <= FC_THRESH_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_CLASS_COUNT: class_count_ff   <= csr_wdata[2:0];
            REG_CLASS0_SIZE: class_size_ff[0] <= csr_wdata[23:0];
            REG_CLASS1_SIZE: class_size_ff[1] <= csr_wdata[23:0];
            REG_CLASS2_SIZE: class_size_ff[2] <= csr_wdata[23:0];
            REG_CLASS3_SIZE: class_size_ff[3] <= csr_wdata[23:0];
            REG_NUM_QUEUES:  num_queues_ff    <= csr_wdata[3:0];
            REG_BUFS_PER_CL: bufs_ff          <= csr_wdata[11:0];
            REG_FC_THRESH:   fc_thr_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   scbp_div #(.N_W(12), .D_W(QCW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (bufs_ff),
      .divisor   (qc_eff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   scbp_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sweep datapath: one queue of the current class per cycle
   always_comb begin
      sweep_q   = rr_ff[CW'(cls_ff)];
      sweep_id  = IDW'(int'(cls_ff) * MAX_QUEUES + int'(sweep_q));
      sweep_cnt = count_ff[sweep_id];
      thr1      = {1'b0, fc_thr_ff} + 9'd1;
      fc_prod   = PW'(thr1) * PW'(sweep_cnt);
      sweep_hit = (sweep_cnt != '0) &&
                  ((mode_ff != MODE_ALLOC_FC) || (int'(div_quo) < int'(fc_prod)));
      if (int'(sweep_q) + 1 == int'(qc_eff)) begin
         sweep_q_nxt = '0;
      end else begin
         sweep_q_nxt = QW'(int'(sweep_q) + 1);
      end
      free_id  = IDW'(int'(fcls_ff) * MAX_QUEUES + int'(fq_ff));
      free_bad = (int'(fcls_ff) >= int'(cc_eff)) || (int'(fq_ff) >= int'(qc_eff)) ||
                 (int'(fslot_ff) >= SLOTS_PER_QUEUE) ||
                 (int'(count_ff[free_id]) >= int'(share_of(int'(fq_ff))));
      tail = int'(head_ff[free_id]) + int'(count_ff[free_id]);
      if (tail >= SLOTS_PER_QUEUE) begin
         tail = tail - SLOTS_PER_QUEUE;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_start_in  = clr_start_ff;
      ring_done_in  = ring_done_ff;
      clr_addr_in   = clr_addr_ff;
      clr_pos_in    = clr_pos_ff;
      mode_in       = mode_ff;
      length_in     = length_ff;
      fcls_in       = fcls_ff;
      fq_in         = fq_ff;
      fslot_in      = fslot_ff;
      cls_in        = cls_ff;
      try_in        = try_ff;
      qhit_in       = qhit_ff;
      res_status_in = res_status_ff;
      res_class_in  = res_class_ff;
      res_queue_in  = res_queue_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_queue_in  = rsp_queue_ff;
      rsp_slot_in   = rsp_slot_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rr_in         = rr_ff;
      div_start     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = clr_addr_ff;
      ram_wdata     = clr_pos_ff;
      ram_raddr     = AW'(int'(sweep_id) * SLOTS_PER_QUEUE + int'(head_ff[sweep_id]));
      qext          = 8'(sweep_q);
      sext          = 16'(ram_rdata);

      case (state_ff)
         S_CLEAR: begin
            if (clr_start_ff) begin
               clr_start_in = 1'b0;
               ring_done_in = 1'b0;
               clr_addr_in  = '0;
               clr_pos_in   = '0;
               div_start    = 1'b1;
            end else if (!ring_done_ff) begin
               ram_we = 1'b1;
               clr_addr_in = clr_addr_ff + AW'(1);
               if (int'(clr_pos_ff) == SLOTS_PER_QUEUE - 1) begin
                  clr_pos_in = '0;
               end else begin
                  clr_pos_in = clr_pos_ff + SW'(1);
               end
               if (int'(clr_addr_ff) == DEPTH - 1) begin
                  ring_done_in = 1'b1;
               end
            end else if (!div_busy) begin
               for (int c = 0; c < MAX_CLASSES; c++) begin
                  rr_in[c] = '0;
                  for (int q = 0; q < MAX_QUEUES; q++) begin
                     head_in[c * MAX_QUEUES + q]  = '0;
                     count_in[c * MAX_QUEUES + q] = share_of(q);
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in   = req_ch.mode;
               length_in = req_ch.length;
               fcls_in   = req_ch.free_class;
               fq_in     = req_ch.free_queue;
               fslot_in  = req_ch.free_slot;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            res_class_in = '0;
            res_queue_in = '0;
            res_slot_in  = '0;
            if (mode_ff == MODE_ALLOC || mode_ff == MODE_ALLOC_FC) begin
               cls_in   = '0;
               state_in = S_CLASS;
            end else if (mode_ff == MODE_FREE) begin
               if (free_bad) begin
                  res_status_in = ST_BAD_FREE;
               end else begin
                  // push the handle at the queue tail
                  ram_we    = 1'b1;
                  ram_waddr = AW'(int'(free_id) * SLOTS_PER_QUEUE + tail);
                  ram_wdata = SW'(fslot_ff);
                  count_in[free_id] = count_ff[free_id] + CNT_W'(1);
                  res_status_in = ST_OK;
               end
               state_in = S_OUT;
            end else begin
               res_status_in = ST_BAD_FREE;
               state_in      = S_OUT;
            end
         end
         S_CLASS: begin
            if (length_ff <= class_size_ff[cls_ff]) begin
               try_in   = '0;
               state_in = S_SWEEP;
            end else if (int'(cls_ff) + 1 >= int'(cc_eff)) begin
               res_status_in = ST_NO_CLASS;
               state_in      = S_OUT;
            end else begin
               cls_in = cls_ff + 2'd1;
            end
         end
         S_SWEEP: begin
            rr_in[CW'(cls_ff)] = sweep_q_nxt;
            if (sweep_hit) begin
               // pop the head; slot comes back from the ring next cycle
               if (int'(head_ff[sweep_id]) == SLOTS_PER_QUEUE - 1) begin
                  head_in[sweep_id] = '0;
               end else begin
                  head_in[sweep_id] = head_ff[sweep_id] + SW'(1);
               end
               count_in[sweep_id] = sweep_cnt - CNT_W'(1);
               qhit_in  = sweep_q;
               res_queue_in = qext[2:0];
               state_in = S_POP;
            end else if (int'(try_ff) + 1 >= int'(qc_eff)) begin
               res_status_in = ST_NO_BUFFER;
               state_in      = S_OUT;
            end else begin
               try_in = try_ff + QCW'(1);
            end
         end
         S_POP: begin
            res_status_in = ST_OK;
            res_class_in  = cls_ff;
            res_slot_in   = sext[7:0];
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_class_in  = res_class_ff;
               rsp_queue_in  = res_queue_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase

      if (cfg_reinit) begin
         clr_start_in = 1'b1;
         state_in     = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_start_ff <= 1'b1;
         ring_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_start_ff <= clr_start_in;
         ring_done_ff <= ring_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      clr_addr_ff   <= clr_addr_in;
      clr_pos_ff    <= clr_pos_in;
      mode_ff       <= mode_in;
      length_ff     <= length_in;
      fcls_ff       <= fcls_in;
      fq_ff         <= fq_in;
      fslot_ff      <= fslot_in;
      cls_ff        <= cls_in;
      try_ff        <= try_in;
      qhit_ff       <= qhit_in;
      res_status_ff <= res_status_in;
      res_class_ff  <= res_class_in;
      res_queue_ff  <= res_queue_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_queue_ff  <= rsp_queue_in;
      rsp_slot_ff   <= rsp_slot_in;
      head_ff       <= head_in;
      count_ff      <= count_in;
      rr_ff         <= rr_in;
   end

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.buf_class = rsp_class_ff;
   assign rsp_ch.buf_queue = rsp_queue_ff;
   assign rsp_ch.buf_slot  = rsp_slot_ff;

   `SCBP_ASSERT_IMP(a_err_fields_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_class_ff == 2'd0 && rsp_queue_ff == 3'd0 && rsp_slot_ff == 8'd0)
   `SCBP_ASSERT_NXT(a_busy_after_transfer, clock, reset, req_ch.valid && req_ch.ready && !cfg_reinit, state_ff == S_DISPATCH)
   `SCBP_ASSERT_NXT(a_pop_follows_hit, clock, reset, state_ff == S_SWEEP && sweep_hit && !cfg_reinit, state_ff == S_POP && int'(qhit_ff) < int'(qc_eff))
endmodule
